// ===== src/bfa_pkg.sv =====
// Shared types and constants for the bitmap frame allocator.
package bfa_pkg;

  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned BIT_W     = 6;
  localparam int unsigned PAGE_W    = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 48;

  localparam logic [ADDR_W-1:0] PAGE_MASK    = 48'h0000_0000_0FFF;
  localparam logic [CNT_W-1:0]  RST_FRAMES   = 13'd4096;
  localparam logic [CNT_W-1:0]  RST_RESERVED = 13'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_BASE = 2'd0,
    CFG_FRAMES      = 2'd1,
    CFG_RESERVED    = 2'd2
  } bfa_cfg_e;

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } bfa_func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_BAD_ADDR = 2'd2
  } bfa_status_e;

  typedef struct packed {
    bfa_func_e          func;
    logic [ADDR_W-1:0]  free_address;
  } bfa_in_t;

  typedef struct packed {
    bfa_status_e        status;
    logic [ADDR_W-1:0]  frame_address;
    logic [CNT_W-1:0]   free_count;
  } bfa_out_t;

  // Result of the first-zero search over one map word.
  typedef struct packed {
    logic              found;
    logic [BIT_W-1:0]  bit_idx;
  } bfa_ffz_t;

endpackage

// ===== src/bfa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bfa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bfa_alu.sv =====
// Shared datapath unit: one 48-bit adder and a first-zero search over a map word.
module bfa_alu (
  input  logic [bfa_pkg::ADDR_W-1:0] add_a_i,
  input  logic [bfa_pkg::ADDR_W-1:0] add_b_i,
  input  logic                       add_ci_i,
  output logic [bfa_pkg::ADDR_W-1:0] sum_o,
  output logic                       co_o,
  input  logic [bfa_pkg::WORD_W-1:0] word_i,
  output bfa_pkg::bfa_ffz_t          ffz_o
);

  logic [bfa_pkg::ADDR_W:0] sum_full;

  assign sum_full = {1'b0, add_a_i} + {1'b0, add_b_i}
                  + {{bfa_pkg::ADDR_W{1'b0}}, add_ci_i};
  assign sum_o    = sum_full[bfa_pkg::ADDR_W-1:0];
  assign co_o     = sum_full[bfa_pkg::ADDR_W];

  // Priority encoder: the lowest clear bit wins.
  always_comb begin
    ffz_o.found   = 1'b0;
    ffz_o.bit_idx = '0;
    for (int i = bfa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        ffz_o.found   = 1'b1;
        ffz_o.bit_idx = bfa_pkg::BIT_W'(i);
      end
    end
  end

endmodule

// ===== src/bitmap_frame_allocator_core.sv =====
// Bitmap page-frame allocator: one usage bit per 4 KiB frame, held in a word RAM.
//
// The block manages up to MAX_FRAMES frames of 4 KiB starting at region_base
// rounded up to 4 KiB. Each input transfer either allocates the lowest free
// frame or frees the frame that holds free_address, and each one produces
// exactly one output transfer with a status, the allocated frame address
// (zero unless an allocation succeeds) and the free frame count afterwards.
// Failures never change state: an allocation with no free frame returns
// "no free frame", and a free below the base, beyond the region or of a frame
// that is already free returns "invalid address". The usage map lives in a
// RAM of MAX_FRAMES/64 words of 64 bits with a registered read port. After
// reset, and after any write to one of the three configuration registers,
// the block sweeps the whole RAM, one word per cycle, to clear it and mark
// the reserved leading frames used; no input transfer is taken during the
// sweep. An allocation scans the map one word per cycle through the
// first-zero search until it hits a free bit, reading 1 to MAX_FRAMES/64
// words, and then forms the frame address on the shared adder; an
// allocation that finds no free bit skips the address step. A free
// subtracts the base on the shared adder, checks the range, reads the word
// and writes it back; a free that fails the base or range check skips the
// read. A finished result waits in the done state, with nothing committed,
// while the output register still holds a stalled transfer. One item is in
// flight at a time; a finished result sits in the output register while the
// next item is accepted and worked on.
module bitmap_frame_allocator_core #(
  parameter int unsigned MAX_FRAMES = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 cfg_we_i,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bfa_pkg::CFG_W-1:0]            cfg_wdata_i,

  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  bfa_pkg::bfa_in_t                     in_data_i,

  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output bfa_pkg::bfa_out_t                    out_data_o
);

  // Map geometry follows from the frame count.
  localparam int unsigned WORDS = (MAX_FRAMES + 63) / 64;
  localparam int unsigned WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned FI_W  = WA_W + bfa_pkg::BIT_W;
  localparam int unsigned OFF_W = bfa_pkg::ADDR_W - bfa_pkg::PAGE_W;
  localparam logic [WA_W-1:0] LAST_WORD = WA_W'(WORDS - 1);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_SWEEP = 9'b000000010,
    S_IDLE  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_AADDR = 9'b000010000,
    S_FSUB  = 9'b000100000,
    S_FCHK  = 9'b001000000,
    S_FBIT  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers and the values derived from them at init.
  logic [bfa_pkg::ADDR_W-1:0] cfg_base_q, cfg_base_d;
  logic [bfa_pkg::CNT_W-1:0]  cfg_frames_q, cfg_frames_d;
  logic [bfa_pkg::CNT_W-1:0]  cfg_rsv_q, cfg_rsv_d;
  logic [bfa_pkg::ADDR_W-1:0] base_q, base_d;
  logic [bfa_pkg::CNT_W-1:0]  total_q, total_d;
  logic [bfa_pkg::CNT_W-1:0]  rsv_q, rsv_d;
  logic [bfa_pkg::CNT_W-1:0]  free_q, free_d;

  // Sequencer registers.
  logic [WA_W-1:0]             sweep_q, sweep_d;
  logic [WA_W-1:0]             scan_q, scan_d;
  logic [WA_W-1:0]             chk_q, chk_d;
  logic                        dv_q, dv_d;
  logic [WA_W-1:0]             wa_q, wa_d;
  logic [FI_W-1:0]             idx_q, idx_d;
  logic [bfa_pkg::WORD_W-1:0]  word_q, word_d;
  logic [bfa_pkg::ADDR_W-1:0]  addr_q, addr_d;
  logic                        below_q, below_d;
  logic [OFF_W-1:0]            off_q, off_d;
  logic [bfa_pkg::BIT_W-1:0]   bsel_q, bsel_d;

  // Result waiting to be committed in the done state.
  bfa_pkg::bfa_status_e        pend_status_q, pend_status_d;
  logic [bfa_pkg::ADDR_W-1:0]  pend_addr_q, pend_addr_d;
  logic                        pend_wr_q, pend_wr_d;
  logic                        pend_inc_q, pend_inc_d;
  logic                        pend_dec_q, pend_dec_d;

  // Output register.
  logic                        out_valid_q;
  bfa_pkg::bfa_out_t           out_data_q;

  // RAM ports.
  logic                        ram_we;
  logic [WA_W-1:0]             ram_waddr;
  logic [bfa_pkg::WORD_W-1:0]  ram_wdata;
  logic                        ram_re;
  logic [WA_W-1:0]             ram_raddr;
  logic [bfa_pkg::WORD_W-1:0]  ram_rdata;

  // Shared unit ports.
  logic [bfa_pkg::ADDR_W-1:0]  add_a, add_b, add_sum;
  logic                        add_ci, add_co;
  bfa_pkg::bfa_ffz_t           ffz;

  // Misc combinational values.
  logic                        in_fire;
  logic                        slot_free;
  logic                        done_fire;
  logic                        cfg_hit;
  logic [bfa_pkg::CNT_W-1:0]   n_clip;
  logic [bfa_pkg::CNT_W-1:0]   r_clip;
  logic [bfa_pkg::CNT_W-1:0]   new_free;
  logic [31:0]                 sw_lo;
  logic [31:0]                 sw_r;
  logic [bfa_pkg::BIT_W-1:0]   sw_rem;
  logic [bfa_pkg::WORD_W-1:0]  sw_word;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign done_fire  = (state_q == S_DONE) && slot_free;

  // A write to any listed register re-initializes the map.
  always_comb begin
    cfg_hit      = 1'b0;
    cfg_base_d   = cfg_base_q;
    cfg_frames_d = cfg_frames_q;
    cfg_rsv_d    = cfg_rsv_q;
    if (cfg_we_i) begin
      unique case (bfa_pkg::bfa_cfg_e'(cfg_idx_i))
        bfa_pkg::CFG_REGION_BASE: begin
          cfg_base_d = cfg_wdata_i[bfa_pkg::ADDR_W-1:0];
          cfg_hit    = 1'b1;
        end
        bfa_pkg::CFG_FRAMES: begin
          cfg_frames_d = cfg_wdata_i[bfa_pkg::CNT_W-1:0];
          cfg_hit      = 1'b1;
        end
        bfa_pkg::CFG_RESERVED: begin
          cfg_rsv_d = cfg_wdata_i[bfa_pkg::CNT_W-1:0];
          cfg_hit   = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // The frame count is clipped to the map size and the reservation to the count.
  always_comb begin
    if (32'(cfg_frames_q) > MAX_FRAMES) begin
      n_clip = bfa_pkg::CNT_W'(MAX_FRAMES);
    end else begin
      n_clip = cfg_frames_q;
    end
    if (cfg_rsv_q > n_clip) begin
      r_clip = n_clip;
    end else begin
      r_clip = cfg_rsv_q;
    end
  end

  // Init pattern for the word being swept: bits below the reservation are set.
  always_comb begin
    sw_lo  = 32'({sweep_q, {bfa_pkg::BIT_W{1'b0}}});
    sw_r   = 32'(rsv_q);
    sw_rem = bfa_pkg::BIT_W'(sw_r - sw_lo);
    if (sw_r >= sw_lo + 32'd64) begin
      sw_word = '1;
    end else if (sw_r <= sw_lo) begin
      sw_word = '0;
    end else begin
      sw_word = ~({bfa_pkg::WORD_W{1'b1}} << sw_rem);
    end
  end

  // The free count that the pending result leaves behind.
  always_comb begin
    if (pend_inc_q) begin
      new_free = free_q + 1'b1;
    end else if (pend_dec_q) begin
      new_free = free_q - 1'b1;
    end else begin
      new_free = free_q;
    end
  end

  // Operand selection for the shared adder.
  always_comb begin
    add_a  = '0;
    add_b  = '0;
    add_ci = 1'b0;
    unique case (state_q)
      S_INIT: begin
        add_a = cfg_base_q;
        add_b = bfa_pkg::PAGE_MASK;
      end
      S_AADDR: begin
        add_a = base_q;
        add_b = bfa_pkg::ADDR_W'({idx_q, {bfa_pkg::PAGE_W{1'b0}}});
      end
      S_FSUB: begin
        add_a  = addr_q;
        add_b  = ~base_q;
        add_ci = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d       = state_q;
    base_d        = base_q;
    total_d       = total_q;
    rsv_d         = rsv_q;
    free_d        = free_q;
    sweep_d       = sweep_q;
    scan_d        = scan_q;
    chk_d         = chk_q;
    dv_d          = dv_q;
    wa_d          = wa_q;
    idx_d         = idx_q;
    word_d        = word_q;
    addr_d        = addr_q;
    below_d       = below_q;
    off_d         = off_q;
    bsel_d        = bsel_q;
    pend_status_d = pend_status_q;
    pend_addr_d   = pend_addr_q;
    pend_wr_d     = pend_wr_q;
    pend_inc_d    = pend_inc_q;
    pend_dec_d    = pend_dec_q;
    ram_we        = 1'b0;
    ram_waddr     = wa_q;
    ram_wdata     = word_q;
    ram_re        = 1'b0;
    ram_raddr     = scan_q;

    unique case (state_q)
      S_INIT: begin
        base_d  = add_sum & ~bfa_pkg::PAGE_MASK;
        total_d = n_clip;
        rsv_d   = r_clip;
        free_d  = n_clip - r_clip;
        sweep_d = '0;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = sw_word;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == LAST_WORD) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.func == bfa_pkg::FN_ALLOC) begin
            scan_d  = '0;
            dv_d    = 1'b0;
            state_d = S_SCAN;
          end else begin
            addr_d  = in_data_i.free_address;
            state_d = S_FSUB;
          end
        end
      end
      S_SCAN: begin
        // Reads run one word ahead of the search on the returned data.
        if (dv_q && ffz.found) begin
          idx_d   = {chk_q, ffz.bit_idx};
          wa_d    = chk_q;
          word_d  = ram_rdata | ({{(bfa_pkg::WORD_W-1){1'b0}}, 1'b1} << ffz.bit_idx);
          state_d = S_AADDR;
        end else if (dv_q && (chk_q == LAST_WORD)) begin
          pend_status_d = bfa_pkg::ST_NO_FREE;
          pend_addr_d   = '0;
          pend_wr_d     = 1'b0;
          pend_inc_d    = 1'b0;
          pend_dec_d    = 1'b0;
          state_d       = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = scan_q;
          chk_d     = scan_q;
          dv_d      = 1'b1;
          scan_d    = scan_q + 1'b1;
        end
      end
      S_AADDR: begin
        pend_inc_d = 1'b0;
        if (32'(idx_q) < 32'(total_q)) begin
          pend_status_d = bfa_pkg::ST_OK;
          pend_addr_d   = add_sum;
          pend_wr_d     = 1'b1;
          pend_dec_d    = 1'b1;
        end else begin
          pend_status_d = bfa_pkg::ST_NO_FREE;
          pend_addr_d   = '0;
          pend_wr_d     = 1'b0;
          pend_dec_d    = 1'b0;
        end
        state_d = S_DONE;
      end
      S_FSUB: begin
        // Carry out of address plus inverted base means no borrow.
        below_d = !add_co;
        off_d   = add_sum[bfa_pkg::ADDR_W-1:bfa_pkg::PAGE_W];
        state_d = S_FCHK;
      end
      S_FCHK: begin
        pend_addr_d = '0;
        pend_dec_d  = 1'b0;
        if (below_q || (off_q >= OFF_W'(total_q))) begin
          pend_status_d = bfa_pkg::ST_BAD_ADDR;
          pend_wr_d     = 1'b0;
          pend_inc_d    = 1'b0;
          state_d       = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = off_q[WA_W+bfa_pkg::BIT_W-1:bfa_pkg::BIT_W];
          wa_d      = off_q[WA_W+bfa_pkg::BIT_W-1:bfa_pkg::BIT_W];
          bsel_d    = off_q[bfa_pkg::BIT_W-1:0];
          state_d   = S_FBIT;
        end
      end
      S_FBIT: begin
        if (ram_rdata[bsel_q]) begin
          word_d        = ram_rdata & ~({{(bfa_pkg::WORD_W-1){1'b0}}, 1'b1} << bsel_q);
          pend_status_d = bfa_pkg::ST_OK;
          pend_wr_d     = 1'b1;
          pend_inc_d    = 1'b1;
        end else begin
          pend_status_d = bfa_pkg::ST_BAD_ADDR;
          pend_wr_d     = 1'b0;
          pend_inc_d    = 1'b0;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // Nothing is committed until the output register can take the result.
        if (slot_free) begin
          ram_we  = pend_wr_q;
          free_d  = new_free;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase

    if (cfg_hit) begin
      state_d = S_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      cfg_base_q   <= '0;
      cfg_frames_q <= bfa_pkg::RST_FRAMES;
      cfg_rsv_q    <= bfa_pkg::RST_RESERVED;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cfg_base_q   <= cfg_base_d;
      cfg_frames_q <= cfg_frames_d;
      cfg_rsv_q    <= cfg_rsv_d;
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q        <= base_d;
    total_q       <= total_d;
    rsv_q         <= rsv_d;
    free_q        <= free_d;
    sweep_q       <= sweep_d;
    scan_q        <= scan_d;
    chk_q         <= chk_d;
    dv_q          <= dv_d;
    wa_q          <= wa_d;
    idx_q         <= idx_d;
    word_q        <= word_d;
    addr_q        <= addr_d;
    below_q       <= below_d;
    off_q         <= off_d;
    bsel_q        <= bsel_d;
    pend_status_q <= pend_status_d;
    pend_addr_q   <= pend_addr_d;
    pend_wr_q     <= pend_wr_d;
    pend_inc_q    <= pend_inc_d;
    pend_dec_q    <= pend_dec_d;
    if (done_fire) begin
      out_data_q.status        <= pend_status_q;
      out_data_q.frame_address <= pend_addr_q;
      out_data_q.free_count    <= new_free;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  bfa_alu u_alu (
    .add_a_i  (add_a),
    .add_b_i  (add_b),
    .add_ci_i (add_ci),
    .sum_o    (add_sum),
    .co_o     (add_co),
    .word_i   (ram_rdata),
    .ffz_o    (ffz)
  );

  bfa_ram #(
    .WIDTH (bfa_pkg::WORD_W),
    .DEPTH (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== src/bfa_checker.sv =====
// Port-level checker for the bitmap frame allocator, bound to the top level.
module bfa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [bfa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input bfa_pkg::bfa_out_t             out_data_o
);

  // A result offered and stalled is still offered in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transfer dropped while stalled");

  // Only one item is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in progress");

  // A register write starts the map sweep, so input is held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == bfa_pkg::CFG_REGION_BASE ||
                 cfg_idx_i == bfa_pkg::CFG_FRAMES ||
                 cfg_idx_i == bfa_pkg::CFG_RESERVED) |=> in_stall_o)
    else $error("input not held off after a configuration write");

  // Only a successful allocation returns a nonzero address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != bfa_pkg::ST_OK) |->
      (out_data_o.frame_address == '0))
    else $error("address returned with a failing status");

  // Frame addresses are always 4 KiB aligned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.frame_address[bfa_pkg::PAGE_W-1:0] == '0))
    else $error("frame address not aligned");

endmodule

bind bitmap_frame_allocator_core bfa_checker u_bfa_checker (.*);
